FILE: hdl/lbrf_pkg.sv
// ----------------------------------------------------------------------------
// lbrf_pkg
// Types, constants and helpers for the line-buffered receive FIFO.
// ----------------------------------------------------------------------------
package lbrf_pkg;

  localparam int DEPTH = 128;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [7:0] RX_MASK = 8'h7f;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_READ  = 2'd1,
    OP_UNGET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_DROPPED    = 2'd2,
    ST_UNGET_FULL = 2'd3
  } status_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [1:0] status;
    logic [7:0] chars_held;
    logic [7:0] lines_held;
  } result_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
    ptr_t       raddr;
  } mem_req_t;

  function automatic ptr_t step_up(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t step_down(input ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
  endfunction

  function automatic logic [7:0] to_byte(input cnt_t c);
    logic [CNT_W+7:0] w;
    w = {8'b0, c};
    return w[7:0];
  endfunction

endpackage

FILE: hdl/lbrf_store.sv
// ----------------------------------------------------------------------------
// lbrf_store
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbrf_store (
  input  logic              clk,
  input  lbrf_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import lbrf_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: hdl/lbrf_ctrl.sv
// ----------------------------------------------------------------------------
// lbrf_ctrl
// Sequencer: pointers, counts, receive/read/unget and the overflow line drop.
// ----------------------------------------------------------------------------
module lbrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  lbrf_pkg::item_t    item,
  output logic               res_valid,
  input  logic               res_ready,
  output lbrf_pkg::result_t  res,
  output lbrf_pkg::mem_req_t req,
  input  logic [7:0]         rdata
);
  import lbrf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_DROP   = 5'b00100,
    S_APPEND = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t     state, state_next;
  ptr_t       rd_ptr, rd_ptr_next;
  ptr_t       wr_ptr, wr_ptr_next;
  cnt_t       char_cnt, char_cnt_next;
  cnt_t       line_cnt, line_cnt_next;
  logic [7:0] hold_byte, hold_byte_next;
  logic [7:0] rchar, rchar_next;
  status_t    status, status_next;
  logic       full;
  logic [7:0] masked;

  assign full   = (char_cnt == cnt_t'(DEPTH));
  assign masked = item.data_byte & RX_MASK;

  always_comb begin
    state_next     = state;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    char_cnt_next  = char_cnt;
    line_cnt_next  = line_cnt;
    hold_byte_next = hold_byte;
    rchar_next     = rchar;
    status_next    = status;
    req            = '{we: 1'b0, waddr: wr_ptr, wdata: 8'h00, raddr: rd_ptr};
    item_ready     = (state == S_IDLE);
    res_valid      = (state == S_RESULT);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          hold_byte_next = masked;
          rchar_next     = 8'h00;
          status_next    = ST_OK;
          state_next     = S_RESULT;
          unique case (op_t'(item.op))
            OP_RECV: begin
              if (full) begin
                status_next = ST_DROPPED;
                state_next  = S_DROP;
              end else begin
                req.we        = 1'b1;
                req.wdata     = masked;
                wr_ptr_next   = step_up(wr_ptr);
                char_cnt_next = char_cnt + cnt_t'(1);
                if (masked == CHAR_CR) begin
                  line_cnt_next = line_cnt + cnt_t'(1);
                end
              end
            end
            OP_READ: begin
              if (char_cnt == '0) begin
                status_next = ST_EMPTY;
              end else begin
                state_next = S_READ;
              end
            end
            OP_UNGET: begin
              if (full) begin
                status_next = ST_UNGET_FULL;
              end else begin
                req.we        = 1'b1;
                req.waddr     = step_down(rd_ptr);
                req.wdata     = item.data_byte;
                rd_ptr_next   = step_down(rd_ptr);
                char_cnt_next = char_cnt + cnt_t'(1);
                if (item.data_byte == CHAR_CR) begin
                  line_cnt_next = line_cnt + cnt_t'(1);
                end
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_READ: begin
        rchar_next    = rdata;
        rd_ptr_next   = step_up(rd_ptr);
        char_cnt_next = char_cnt - cnt_t'(1);
        if (rdata == CHAR_CR && line_cnt != '0) begin
          line_cnt_next = line_cnt - cnt_t'(1);
        end
        state_next = S_RESULT;
      end
      S_DROP: begin
        rd_ptr_next   = step_up(rd_ptr);
        char_cnt_next = char_cnt - cnt_t'(1);
        req.raddr     = step_up(rd_ptr);
        if (rdata == CHAR_CR) begin
          if (line_cnt != '0) begin
            line_cnt_next = line_cnt - cnt_t'(1);
          end
          state_next = S_APPEND;
        end else if (char_cnt == cnt_t'(1)) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        req.we        = 1'b1;
        req.wdata     = hold_byte;
        wr_ptr_next   = step_up(wr_ptr);
        char_cnt_next = char_cnt + cnt_t'(1);
        if (hold_byte == CHAR_CR) begin
          line_cnt_next = line_cnt + cnt_t'(1);
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      char_cnt <= '0;
      line_cnt <= '0;
    end else begin
      state    <= state_next;
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      char_cnt <= char_cnt_next;
      line_cnt <= line_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    rchar     <= rchar_next;
    status    <= status_next;
  end

  assign res = '{read_char:  rchar,
                 status:     status,
                 chars_held: to_byte(char_cnt),
                 lines_held: to_byte(line_cnt)};

endmodule

FILE: hdl/line_buffered_receive_fifo_top.sv
// ----------------------------------------------------------------------------
// line_buffered_receive_fifo_top
// Receive character FIFO that counts CR-terminated lines and drops the oldest
// line when a byte arrives into a full buffer.
//
//   channel   dir  handshake                    payload
//   item      in   item_valid / item_ready      item   (op, data_byte)
//   result    out  result_valid / result_ready  result (read_char, status,
//                                                        chars_held, lines_held)
//
// One item at a time: unget, plain receive, an empty read and unused ops go
// straight to a ready result, a read of a held char passes S_READ first; a
// receive into a full buffer passes S_DROP, dropping n chars (at most DEPTH),
// one per cycle on the store read port, then S_APPEND.
// Reset is synchronous and clears pointers and counts; the store is not
// cleared. A stalled result sits in the output register while the next item
// is accepted and worked.
// ----------------------------------------------------------------------------
module line_buffered_receive_fifo_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lbrf_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output lbrf_pkg::result_t result
);
  import lbrf_pkg::*;

  mem_req_t   req;
  logic [7:0] rdata;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  lbrf_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  lbrf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .req        (req),
    .rdata      (rdata)
  );

  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result <= res;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous one in flight");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_EMPTY |->
      result.read_char == 8'h00 && result.chars_held == 8'h00)
    else $error("empty read returned data");

  a_unget_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNGET_FULL |->
      result.chars_held == to_byte(cnt_t'(DEPTH)))
    else $error("unget refused while not full");

  a_lines_le_chars: assert property (@(posedge clk) disable iff (rst)
    result_valid && DEPTH < 256 |-> result.lines_held <= result.chars_held)
    else $error("line count exceeds char count");

endmodule
